>>> design/lpd_pkg.sv
// lpd_pkg: shared types and codes of the lp distance query engine
// no dependencies

package lpd_pkg;

    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic REG_EXPONENT_P    = 1'b0;
    localparam logic REG_VALUES_IN_USE = 1'b1;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [31:0] b;
    } t_mul_req;

    typedef struct packed {
        logic        done;
        logic [63:0] prod;
        logic        ovf;
    } t_mul_rsp;

endpackage

>>> design/lpd_mul.sv
// lpd_mul: 64 by 32 bit multiply with overflow flag, one 32x32 multiplier used twice
// depends on lpd_pkg

module lpd_mul
    import lpd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    logic        r_s1;
    logic        r_s2;
    logic [31:0] r_ah;
    logic [31:0] r_b;
    logic [63:0] r_lo;
    logic [63:0] r_hi;
    logic [31:0] n_x;
    logic [31:0] n_y;
    logic [63:0] n_mult;
    logic [32:0] n_mid;

    assign n_x    = r_s1 ? r_ah : i_req.a[31:0];
    assign n_y    = r_s1 ? r_b : i_req.b;
    assign n_mult = 64'(n_x) * 64'(n_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= 1'b0;
            r_s2 <= 1'b0;
        end else begin
            r_s1 <= i_req.start;
            r_s2 <= r_s1;
        end
        if (i_req.start) begin
            r_lo <= n_mult;
            r_ah <= i_req.a[63:32];
            r_b  <= i_req.b;
        end
        if (r_s1) begin
            r_hi <= n_mult;
        end
    end

    assign n_mid      = {1'b0, r_lo[63:32]} + {1'b0, r_hi[31:0]};
    assign o_rsp.done = r_s2;
    assign o_rsp.prod = {n_mid[31:0], r_lo[31:0]};
    assign o_rsp.ovf  = (|r_hi[63:32]) | n_mid[32];

endmodule

>>> design/lpd_store.sv
// lpd_store: sample memories of set a and set b, one write port, registered reads
// no dependencies

module lpd_store #(
    parameter int ROWS   = 64,
    parameter int VALUES = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic                                 i_wset,
    input  logic [$clog2(ROWS*VALUES)-1:0]       i_waddr,
    input  logic signed [15:0]                   i_wdata,
    input  logic [$clog2(ROWS*VALUES)-1:0]       i_raddr_a,
    input  logic [$clog2(ROWS*VALUES)-1:0]       i_raddr_b,
    input  logic                                 i_rsel_b,
    output logic signed [15:0]                   o_rdata_a,
    output logic signed [15:0]                   o_rdata_b
);

    localparam int DEPTH = ROWS * VALUES;

    logic signed [15:0] mem_a [DEPTH];
    logic signed [15:0] mem_b [DEPTH];
    logic signed [15:0] r_a2;
    logic signed [15:0] r_b1;
    logic               r_sel;

    always_ff @(posedge i_clk) begin
        if (i_we && !i_wset) begin
            mem_a[i_waddr] <= i_wdata;
        end
        if (i_we && i_wset) begin
            mem_b[i_waddr] <= i_wdata;
        end
        o_rdata_a <= mem_a[i_raddr_a];
        r_a2      <= mem_a[i_raddr_b];
        r_b1      <= mem_b[i_raddr_b];
        r_sel     <= i_rsel_b;
    end

    assign o_rdata_b = r_sel ? r_b1 : r_a2;

endmodule

>>> design/lp_distance_query_engine.sv
// lp_distance_query_engine: top level, config registers and query sequencer
// depends on lpd_pkg, lpd_mul, lpd_store
//
// channel  dir  handshake              payload
// in       in   i_in_valid/o_in_ready  i_cmd i_set_select i_row_index i_column_index
//                                      i_sample i_other_row
// out      out  o_out_valid/i_out_ready o_distance o_saturated
// config   in   apb psel/penable/pready paddr pwdata prdata
//
// a load beat writes one sample; a query takes |a-b| to the power p for each of
// the n values in use, sums them and finds the root bit by bit on the shared
// multiplier of lpd_mul; a power chain stops early once it overflows
// o_in_ready is low while a query runs or its beat waits on the output
// synchronous active-low reset; memories have no reset

module lp_distance_query_engine
    import lpd_pkg::*;
#(
    parameter int ROWS   = 64,
    parameter int VALUES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_cmd,
    input  logic               i_set_select,
    input  logic [5:0]         i_row_index,
    input  logic [5:0]         i_column_index,
    input  logic signed [15:0] i_sample,
    input  logic [5:0]         i_other_row,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [31:0]        o_distance,
    output logic               o_saturated,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AW = $clog2(ROWS * VALUES);
    localparam int CW = $clog2(VALUES + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_DIFF, S_MSTART, S_MWAIT, S_ACC, S_RCAND, S_RCMP, S_FINISH
    } t_state;

    t_state      r_state;
    logic [3:0]  r_exponent_p;
    logic [6:0]  r_values_in_use;
    logic [3:0]  r_p;
    logic [3:0]  r_k;
    logic [CW-1:0] r_n;
    logic [CW-1:0] r_m;
    logic [AW-1:0] r_base_a;
    logic [AW-1:0] r_base_b;
    logic        r_sel;
    logic [63:0] r_acc;
    logic [63:0] r_sum;
    logic [31:0] r_opnd;
    logic [31:0] r_root;
    logic [4:0]  r_bit;
    logic        r_sat;
    logic        r_over;
    logic        r_in_root;
    logic        r_out_valid;
    logic [31:0] r_distance;
    logic        r_saturated;

    logic          n_accept;
    logic          n_we;
    logic [AW-1:0] n_waddr;
    logic [CW-1:0] n_cnt;
    logic          n_range;
    logic signed [15:0] n_rd_a;
    logic signed [15:0] n_rd_b;
    logic signed [16:0] n_diff;
    logic [15:0]   n_mag;
    logic [64:0]   n_add;
    logic [3:0]    n_k1;
    t_state        n_post;
    t_mul_req      n_req;
    t_mul_rsp      n_rsp;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_EXPONENT_P) ? {28'd0, r_exponent_p}
                                                 : {25'd0, r_values_in_use};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exponent_p    <= 4'd2;
            r_values_in_use <= 7'd64;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_EXPONENT_P:    r_exponent_p    <= pwdata[3:0];
                REG_VALUES_IN_USE: r_values_in_use <= pwdata[6:0];
                default:           r_exponent_p    <= r_exponent_p;
            endcase
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign n_accept   = i_in_valid && o_in_ready;
    assign n_we       = n_accept && (i_cmd == CMD_LOAD) && (int'(i_row_index) < ROWS)
                        && (int'(i_column_index) < VALUES);
    assign n_waddr    = AW'(AW'(i_row_index) * AW'(VALUES)) + AW'(i_column_index);
    assign n_cnt      = (int'(r_values_in_use) > VALUES) ? CW'(VALUES) : CW'(r_values_in_use);
    assign n_range    = (int'(i_row_index) < ROWS) && (int'(i_other_row) < ROWS);

    lpd_store #(
        .ROWS   (ROWS),
        .VALUES (VALUES)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (n_we),
        .i_wset    (i_set_select),
        .i_waddr   (n_waddr),
        .i_wdata   (i_sample),
        .i_raddr_a (r_base_a + AW'(r_m)),
        .i_raddr_b (r_base_b + AW'(r_m)),
        .i_rsel_b  (r_sel),
        .o_rdata_a (n_rd_a),
        .o_rdata_b (n_rd_b)
    );

    assign n_diff = 17'(n_rd_a) - 17'(n_rd_b);
    assign n_mag  = n_diff[16] ? 16'(-n_diff) : n_diff[15:0];
    assign n_add  = {1'b0, r_sum} + {1'b0, r_acc};
    assign n_k1   = r_k + 4'd1;
    assign n_post = r_in_root ? S_RCMP : S_ACC;

    assign n_req.start = (r_state == S_MSTART);
    assign n_req.a     = r_acc;
    assign n_req.b     = r_opnd;

    lpd_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (n_req),
        .o_rsp   (n_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_FINISH && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (n_accept && i_cmd == CMD_QUERY) begin
                        r_p      <= (r_exponent_p == 4'd0) ? 4'd1 : r_exponent_p;
                        r_n      <= n_cnt;
                        r_m      <= '0;
                        r_sum    <= '0;
                        r_sat    <= 1'b0;
                        r_root   <= '0;
                        r_bit    <= 5'd31;
                        r_sel    <= i_set_select;
                        r_base_a <= AW'(AW'(i_row_index) * AW'(VALUES));
                        r_base_b <= AW'(AW'(i_other_row) * AW'(VALUES));
                        if (!n_range) begin
                            r_state <= S_FINISH;
                        end else if (n_cnt == '0) begin
                            r_state <= S_RCAND;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    r_opnd    <= 32'(n_mag);
                    r_acc     <= 64'd1;
                    r_k       <= '0;
                    r_in_root <= 1'b0;
                    r_state   <= S_MSTART;
                end
                S_MSTART: begin
                    r_state <= S_MWAIT;
                end
                S_MWAIT: begin
                    if (n_rsp.done) begin
                        if (n_rsp.ovf) begin
                            r_acc <= ALL_ONES;
                            if (r_in_root) begin
                                r_over <= 1'b1;
                            end else begin
                                r_sat <= 1'b1;
                            end
                            r_state <= n_post;
                        end else begin
                            r_acc <= n_rsp.prod;
                            r_k   <= n_k1;
                            r_state <= (n_k1 == r_p) ? n_post : S_MSTART;
                        end
                    end
                end
                S_ACC: begin
                    if (n_add[64]) begin
                        r_sum <= ALL_ONES;
                        r_sat <= 1'b1;
                    end else begin
                        r_sum <= n_add[63:0];
                    end
                    r_m <= r_m + CW'(1);
                    r_state <= ((r_m + CW'(1)) == r_n) ? S_RCAND : S_RD;
                end
                S_RCAND: begin
                    r_opnd    <= r_root | (32'd1 << r_bit);
                    r_acc     <= 64'd1;
                    r_k       <= '0;
                    r_over    <= 1'b0;
                    r_in_root <= 1'b1;
                    r_state   <= S_MSTART;
                end
                S_RCMP: begin
                    if (!r_over && r_acc <= r_sum) begin
                        r_root <= r_opnd;
                    end
                    if (r_bit == 5'd0) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_bit   <= r_bit - 5'd1;
                        r_state <= S_RCAND;
                    end
                end
                S_FINISH: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_distance  <= r_root;
                        r_saturated <= r_sat;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_distance  = r_distance;
    assign o_saturated = r_saturated;

    a_mul_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_rsp.done |-> $past(n_req.start, 2))
        else $error("multiplier result without matching start");

    a_mul_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_req.start |=> !n_req.start)
        else $error("multiplier restarted while busy");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_accept && i_cmd == CMD_QUERY) |=> !o_in_ready)
        else $error("ready during a query");

    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_we |-> (r_state == S_IDLE))
        else $error("store written during a query");

endmodule
